@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks used by the top-level controller module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge of clk_i outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that ante implies cons at the same edge
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/msc_pkg.sv @@
// ---------------------------------------------------------------------------
// Motorized switch controller package
// Types and constants shared by the controller modules.
// ---------------------------------------------------------------------------
package msc_pkg;

  typedef enum logic [2:0] {
    ACT_OFF        = 3'd0,
    ACT_ON         = 3'd1,
    ACT_TOGGLE     = 3'd2,
    ACT_SHORT      = 3'd3,
    ACT_LONG       = 3'd4,
    ACT_DONE       = 3'd5,
    ACT_CLEAR_ERR  = 3'd6,
    ACT_TICK       = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_TO_ON  = 2'd1,
    MODE_TO_OFF = 2'd2,
    MODE_ERROR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    LED_NONE     = 2'd0,
    LED_ERROR    = 2'd1,
    LED_FEEDBACK = 2'd2,
    LED_PAIRING  = 2'd3
  } led_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_ORIENT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LOW_BAT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd2;

  localparam logic [6:0]  LowBatReset  = 7'd10;
  localparam logic [15:0] TimeoutReset = 16'd1500;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] battery_percent;
  } in_item_t;

  typedef struct packed {
    logic [1:0] machine_mode;
    logic       logical_position;
    logic       physical_position;
    logic       motor_enable;
    logic       motor_direction;
    logic [1:0] led_event;
    logic       factory_reset_pulse;
    logic       pairing_active;
  } out_item_t;

  typedef struct packed {
    logic        orientation_inverted;
    logic [6:0]  low_battery_limit;
    logic [15:0] motion_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    mode_e mode;
    logic  timeout_zero;
    logic  pairing_flag;
  } core_status_t;

endpackage

@@ design/msc_in_stage.sv @@
// ---------------------------------------------------------------------------
// Input stage
// Registers one request and holds it until the core takes it.
// ---------------------------------------------------------------------------
module msc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  msc_pkg::in_item_t in_data_i,
  input  logic              take_i,
  output logic              valid_o,
  output msc_pkg::in_item_t item_o
);
  import msc_pkg::*;

  logic     valid_d, valid_q;
  logic     accept;
  in_item_t item_q;

  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = accept | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ design/msc_core.sv @@
// ---------------------------------------------------------------------------
// Controller core
// Holds mode, position, timeout and pairing state and forms the result.
// ---------------------------------------------------------------------------
module msc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  msc_pkg::in_item_t     item_i,
  input  msc_pkg::cfg_t         cfg_i,
  output msc_pkg::out_item_t    result_o,
  output msc_pkg::core_status_t status_o
);
  import msc_pkg::*;

  mode_e       mode_d, mode_q;
  logic        pos_d, pos_q;
  logic [15:0] cnt_d, cnt_q;
  logic        pair_d, pair_q;
  led_e        led;
  logic        factory;
  logic        target;
  logic        is_move;
  logic        moving_q;
  logic [15:0] cnt_dec;
  logic [15:0] load_val;

  assign moving_q = (mode_q == MODE_TO_ON) || (mode_q == MODE_TO_OFF);
  assign cnt_dec  = (cnt_q != 16'd0) ? (cnt_q - 16'd1) : cnt_q;
  assign load_val = (cfg_i.motion_timeout_ticks != 16'd0) ? cfg_i.motion_timeout_ticks
                                                          : 16'd1;

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    pair_d  = pair_q;
    led     = LED_NONE;
    factory = 1'b0;
    target  = 1'b0;
    is_move = 1'b0;
    case (action_e'(item_i.action))
      ACT_OFF: begin
        target  = cfg_i.orientation_inverted;
        is_move = 1'b1;
      end
      ACT_ON: begin
        target  = ~cfg_i.orientation_inverted;
        is_move = 1'b1;
      end
      ACT_TOGGLE, ACT_SHORT: begin
        target  = ~pos_q;
        is_move = 1'b1;
      end
      ACT_LONG: begin
        pair_d  = 1'b1;
        led     = LED_PAIRING;
        factory = 1'b1;
      end
      ACT_DONE: begin
        if (moving_q) begin
          pos_d = (mode_q == MODE_TO_ON);
          led   = LED_FEEDBACK;
        end
        mode_d = MODE_IDLE;
        cnt_d  = 16'd0;
      end
      ACT_CLEAR_ERR: begin
        mode_d = MODE_IDLE;
        cnt_d  = 16'd0;
      end
      ACT_TICK: begin
        if (moving_q) begin
          cnt_d = cnt_dec;
          if (cnt_dec == 16'd0) begin
            pos_d  = (mode_q == MODE_TO_ON);
            led    = LED_FEEDBACK;
            mode_d = MODE_IDLE;
          end
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
    if (is_move && (mode_q == MODE_IDLE)) begin
      if (item_i.battery_percent <= cfg_i.low_battery_limit) begin
        mode_d = MODE_ERROR;
        led    = LED_ERROR;
      end else begin
        mode_d = target ? MODE_TO_ON : MODE_TO_OFF;
        cnt_d  = load_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= 1'b0;
      cnt_q  <= 16'd0;
      pair_q <= 1'b0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      pair_q <= pair_d;
    end
  end

  always_comb begin
    result_o.machine_mode        = mode_d;
    result_o.logical_position    = pos_d ^ cfg_i.orientation_inverted;
    result_o.physical_position   = pos_d;
    result_o.motor_enable        = (mode_d == MODE_TO_ON) || (mode_d == MODE_TO_OFF);
    result_o.motor_direction     = (mode_d == MODE_TO_ON);
    result_o.led_event           = led;
    result_o.factory_reset_pulse = factory;
    result_o.pairing_active      = pair_d;
  end

  assign status_o.mode         = mode_q;
  assign status_o.timeout_zero = (cnt_q == 16'd0);
  assign status_o.pairing_flag = pair_q;

endmodule

@@ design/msc_out_stage.sv @@
// ---------------------------------------------------------------------------
// Output stage
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module msc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  msc_pkg::out_item_t result_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output msc_pkg::out_item_t out_data_o
);
  import msc_pkg::*;

  logic      valid_d, valid_q;
  out_item_t data_q;

  assign free_o  = ~valid_q | ~out_stall_i;
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ design/motorized_switch_controller.sv @@
// A request held in the input register passes through the core into the output register,
// which drives out_data_o. Throughput: one request per cycle while out_stall_i is low;
// the input and output registers each hold one item, with the core's state update between.
// Reset (rst_ni low, asynchronous): mode idle, position off, timeout zero, pairing clear,
// configuration back to orientation normal, battery limit 10, timeout 1500 ticks.
// ---------------------------------------------------------------------------
// Motorized switch controller
// Turns switch commands and ticks into motor moves, position and LED events.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module motorized_switch_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  msc_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output msc_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [msc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [msc_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import msc_pkg::*;

  cfg_t         cfg_q;
  in_item_t     item;
  logic         item_valid;
  logic         out_free;
  logic         advance;
  out_item_t    result;
  core_status_t status;
  logic         moving;
  logic         rsp_factory;
  logic         rsp_paired;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orientation_inverted <= 1'b0;
      cfg_q.low_battery_limit    <= LowBatReset;
      cfg_q.motion_timeout_ticks <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIENT:  cfg_q.orientation_inverted <= cfg_wdata_i[0];
        REG_LOW_BAT: cfg_q.low_battery_limit    <= cfg_wdata_i[6:0];
        REG_TIMEOUT: cfg_q.motion_timeout_ticks <= cfg_wdata_i;
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  assign advance = item_valid & out_free;

  msc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (advance),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  msc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .cfg_i     (cfg_q),
    .result_o  (result),
    .status_o  (status)
  );

  msc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign moving      = (status.mode == MODE_TO_ON) || (status.mode == MODE_TO_OFF);
  assign rsp_factory = out_valid_o && out_data_o.factory_reset_pulse;
  assign rsp_paired  = out_data_o.pairing_active && (out_data_o.led_event == LED_PAIRING);

  `ASSERT_IMPL(a_move_has_count, moving, !status.timeout_zero, "moving with empty timeout")
  `ASSERT_CLK(a_pair_sticky, !$past(status.pairing_flag) || status.pairing_flag, "pairing lost")
  `ASSERT_IMPL(a_no_stall_when_empty, !out_valid_o, !in_stall_o, "input stalled with empty output")
  `ASSERT_IMPL(a_factory_pairs, rsp_factory, rsp_paired, "factory pulse without pairing")

endmodule
